// ===== design/spp_pkg.sv =====
`default_nettype none

package spp_pkg;

   // Default sizes of the block.
   localparam int SPP_MAX_WIDTH   = 256;
   localparam int SPP_HEIGHT_BITS = 16;
   localparam int SPP_MAX_PIECES  = 1024;

   // Configuration register indexes (paddr[2]).
   localparam logic REG_PLATE_WIDTH  = 1'b0;
   localparam logic REG_PLATE_HEIGHT = 1'b1;

   localparam logic [8:0]  PLATE_WIDTH_RESET  = 9'd256;
   localparam logic [15:0] PLATE_HEIGHT_RESET = 16'd65535;

   // Which pass the datapath is running over the skyline memory.
   typedef logic [1:0] spp_phase_type;
   localparam spp_phase_type PH_NONE   = 2'd0;
   localparam spp_phase_type PH_SCAN   = 2'd1;
   localparam spp_phase_type PH_UPDATE = 2'd2;
   localparam spp_phase_type PH_SWEEP  = 2'd3;

   typedef struct packed {
      spp_phase_type phase;
      logic          load;
      logic          start_scan;
      logic          start_update;
      logic          start_sweep;
      logic          out_load;
   } spp_cmd_type;

   typedef struct packed {
      logic busy;
      logic ok;
      logic found;
      logic last;
   } spp_status_type;

endpackage

`default_nettype wire

// ===== design/skyline_piece_placer_top.sv =====
`default_nettype none

// Skyline piece placer: packs rectangular pieces bottom-left onto a plate.
// Input channel req_*: one piece per item (width, height, rotate, last mark),
// taken when req_valid is high and req_stall low. Result channel rsp_*: one
// item per piece, taken when rsp_valid is high and rsp_stall low.
// Plate width and height are set through the APB-style port (width at byte
// address 0, height at 4). The user must write them only while the block
// is idle; the block itself does not enforce this. A placed piece gives its
// result after one pass over the plate columns through the skyline memory
// to find the flat run, then one pass over the piece's columns to raise
// them. The next item is taken in the cycle after the result is loaded. A
// rejected piece skips both passes, and a piece for which no flat run fits
// skips the second. A last piece adds a sweep that sums the waste and
// clears the skyline.
// The result sits in an output register; the next item is accepted while it
// waits, but its own result is held back until the receiver takes the first.
// After reset the skyline is cleared by a sweep, during which req_stall
// stays high; configuration writes are taken as ever.
module skyline_piece_placer_top #(
   parameter int MAX_WIDTH   = spp_pkg::SPP_MAX_WIDTH,
   parameter int HEIGHT_BITS = spp_pkg::SPP_HEIGHT_BITS,
   parameter int MAX_PIECES  = spp_pkg::SPP_MAX_PIECES
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_piece_width,
   input  wire logic [15:0] req_piece_height,
   input  wire logic        req_rotate,
   input  wire logic        req_last_piece,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_placed,
   output logic [7:0]       rsp_pos_x,
   output logic [15:0]      rsp_pos_y,
   output logic             rsp_final_result,
   output logic [10:0]      rsp_placed_count,
   output logic [23:0]      rsp_waste_area,
   output logic [8:0]       rsp_waste_columns,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import spp_pkg::*;

   logic [8:0]     plate_width_ff, plate_width_in;
   logic [15:0]    plate_height_ff, plate_height_in;
   logic           csr_write;
   spp_cmd_type    cmd;
   spp_status_type status;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      plate_width_in  = plate_width_ff;
      plate_height_in = plate_height_ff;
      if (csr_write) begin
         if (paddr[2] == REG_PLATE_HEIGHT) begin
            plate_height_in = pwdata[15:0];
         end else begin
            plate_width_in = pwdata[8:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plate_width_ff  <= PLATE_WIDTH_RESET;
         plate_height_ff <= PLATE_HEIGHT_RESET;
      end else begin
         plate_width_ff  <= plate_width_in;
         plate_height_ff <= plate_height_in;
      end
   end

   assign prdata = (paddr[2] == REG_PLATE_WIDTH) ? {23'd0, plate_width_ff}
                                                 : {16'd0, plate_height_ff};

   spp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   spp_dpath #(
      .MAX_WIDTH   (MAX_WIDTH),
      .HEIGHT_BITS (HEIGHT_BITS),
      .MAX_PIECES  (MAX_PIECES)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .plate_width       (plate_width_ff),
      .plate_height      (plate_height_ff),
      .req_piece_width   (req_piece_width),
      .req_piece_height  (req_piece_height),
      .req_rotate        (req_rotate),
      .req_last_piece    (req_last_piece),
      .rsp_placed        (rsp_placed),
      .rsp_pos_x         (rsp_pos_x),
      .rsp_pos_y         (rsp_pos_y),
      .rsp_final_result  (rsp_final_result),
      .rsp_placed_count  (rsp_placed_count),
      .rsp_waste_area    (rsp_waste_area),
      .rsp_waste_columns (rsp_waste_columns)
   );

endmodule

`default_nettype wire

// ===== design/spp_ram.sv =====
`default_nettype none

module spp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/spp_ctrl.sv =====
`default_nettype none

module spp_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   input  wire spp_pkg::spp_status_type status,
   output spp_pkg::spp_cmd_type         cmd
);
   import spp_pkg::*;

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_PREP   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_UPDATE = 3'd4;
   localparam logic [2:0] ST_SWEEP  = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      out_free = !rsp_valid_ff || !rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.phase = PH_SWEEP;
            if (!status.busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (status.ok) begin
               cmd.start_scan = 1'b1;
               state_in       = ST_SCAN;
            end else if (status.last) begin
               cmd.start_sweep = 1'b1;
               state_in        = ST_SWEEP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            cmd.phase = PH_SCAN;
            if (!status.busy) begin
               if (status.found) begin
                  cmd.start_update = 1'b1;
                  state_in         = ST_UPDATE;
               end else if (status.last) begin
                  cmd.start_sweep = 1'b1;
                  state_in        = ST_SWEEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_UPDATE: begin
            cmd.phase = PH_UPDATE;
            if (!status.busy) begin
               if (status.last) begin
                  cmd.start_sweep = 1'b1;
                  state_in        = ST_SWEEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            cmd.phase = PH_SWEEP;
            if (!status.busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_accept_to_prep: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_PREP))
      else $error("accepted item did not move the controller to preparation");

   a_start_when_drained: assert property (@(posedge clock) disable iff (reset)
      (cmd.start_scan || cmd.start_update || cmd.start_sweep) |-> !status.busy)
      else $error("pass started while the previous one was still running");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the done state");
`endif

endmodule

`default_nettype wire

// ===== design/spp_dpath.sv =====
`default_nettype none

module spp_dpath #(
   parameter int MAX_WIDTH   = spp_pkg::SPP_MAX_WIDTH,
   parameter int HEIGHT_BITS = spp_pkg::SPP_HEIGHT_BITS,
   parameter int MAX_PIECES  = spp_pkg::SPP_MAX_PIECES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire spp_pkg::spp_cmd_type cmd,
   output spp_pkg::spp_status_type   status,
   input  wire logic [8:0]           plate_width,
   input  wire logic [15:0]          plate_height,
   input  wire logic [15:0]          req_piece_width,
   input  wire logic [15:0]          req_piece_height,
   input  wire logic                 req_rotate,
   input  wire logic                 req_last_piece,
   output logic                      rsp_placed,
   output logic [7:0]                rsp_pos_x,
   output logic [15:0]               rsp_pos_y,
   output logic                      rsp_final_result,
   output logic [10:0]               rsp_placed_count,
   output logic [23:0]               rsp_waste_area,
   output logic [8:0]                rsp_waste_columns
);
   import spp_pkg::*;

   localparam int COL_BITS  = $clog2(MAX_WIDTH);
   localparam int PW_BITS   = ($clog2(MAX_WIDTH + 1) > 9) ? $clog2(MAX_WIDTH + 1) : 9;
   localparam int CALC_BITS = ((HEIGHT_BITS > 16) ? HEIGHT_BITS : 16) + 1;
   localparam int PT_BITS   = $clog2(MAX_PIECES + 1);

   // Column counters and the read pipeline of the skyline memory.
   logic [PW_BITS-1:0]     col_ff, col_in;
   logic [PW_BITS-1:0]     end_ff, end_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [COL_BITS-1:0]    rd_col_ff, rd_col_in;

   // Current item.
   logic [PW_BITS-1:0]     w_ff, w_in;
   logic [15:0]            h_ff, h_in;
   logic                   last_ff, last_in;
   logic                   ok_ff, ok_in;

   // Scan state: the current flat run and the best position so far.
   logic [HEIGHT_BITS-1:0] run_h_ff, run_h_in;
   logic [PW_BITS-1:0]     run_len_ff, run_len_in;
   logic                   found_ff, found_in;
   logic [COL_BITS-1:0]    best_x_ff, best_x_in;
   logic [HEIGHT_BITS-1:0] best_v_ff, best_v_in;
   logic [CALC_BITS-1:0]   best_top_ff, best_top_in;

   // Layout totals.
   logic [PT_BITS-1:0]     total_ff, total_in;
   logic [23:0]            area_ff, area_in;
   logic [8:0]             cols_ff, cols_in;

   // Result register.
   logic                   placed_ff, placed_in;
   logic [7:0]             pos_x_ff, pos_x_in;
   logic [15:0]            pos_y_ff, pos_y_in;
   logic                   final_ff, final_in;
   logic [10:0]            count_ff, count_in;
   logic [23:0]            waste_area_ff, waste_area_in;
   logic [8:0]             waste_cols_ff, waste_cols_in;

   logic [PW_BITS-1:0]     pw;
   logic [15:0]            sel_w, sel_h;
   logic                   item_ok;
   logic                   issue;
   logic [HEIGHT_BITS-1:0] v;
   logic [CALC_BITS-1:0]   top;
   logic [CALC_BITS-1:0]   ph_ext;
   logic                   same;
   logic [PW_BITS-1:0]     run_len_next;
   logic [PW_BITS-1:0]     start_col;

   logic                   ram_we;
   logic [HEIGHT_BITS-1:0] ram_wdata;

   assign pw = (PW_BITS'(plate_width) > PW_BITS'(MAX_WIDTH)) ? PW_BITS'(MAX_WIDTH)
                                                             : PW_BITS'(plate_width);
   assign sel_w   = req_rotate ? req_piece_height : req_piece_width;
   assign sel_h   = req_rotate ? req_piece_width  : req_piece_height;
   assign item_ok = (sel_w != 16'd0) && (sel_h != 16'd0) && (sel_w <= 16'(pw))
                    && (sel_h <= plate_height);

   assign issue        = (col_ff < end_ff);
   assign ph_ext       = CALC_BITS'(plate_height);
   assign top          = CALC_BITS'(v) + CALC_BITS'(h_ff);
   assign same         = (rd_col_ff != '0) && (v == run_h_ff);
   assign run_len_next = same ? (run_len_ff + PW_BITS'(1)) : PW_BITS'(1);
   // Left column of a run of w columns that ends at the column just read.
   assign start_col    = PW_BITS'(rd_col_ff) + PW_BITS'(1) - w_ff;

   assign ram_we    = rd_valid_ff && ((cmd.phase == PH_UPDATE) || (cmd.phase == PH_SWEEP));
   assign ram_wdata = (cmd.phase == PH_UPDATE) ? (v + HEIGHT_BITS'(h_ff)) : '0;

   spp_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (MAX_WIDTH)
   ) u_skyline (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (rd_col_ff),
      .wr_data (ram_wdata),
      .rd_addr (col_ff[COL_BITS-1:0]),
      .rd_data (v)
   );

   always_comb begin
      col_in        = issue ? (col_ff + PW_BITS'(1)) : col_ff;
      end_in        = end_ff;
      rd_valid_in   = issue;
      rd_col_in     = col_ff[COL_BITS-1:0];
      w_in          = w_ff;
      h_in          = h_ff;
      last_in       = last_ff;
      ok_in         = ok_ff;
      run_h_in      = run_h_ff;
      run_len_in    = run_len_ff;
      found_in      = found_ff;
      best_x_in     = best_x_ff;
      best_v_in     = best_v_ff;
      best_top_in   = best_top_ff;
      total_in      = total_ff;
      area_in       = area_ff;
      cols_in       = cols_ff;
      placed_in     = placed_ff;
      pos_x_in      = pos_x_ff;
      pos_y_in      = pos_y_ff;
      final_in      = final_ff;
      count_in      = count_ff;
      waste_area_in = waste_area_ff;
      waste_cols_in = waste_cols_ff;

      if (cmd.load) begin
         w_in     = sel_w[PW_BITS-1:0];
         h_in     = sel_h;
         last_in  = req_last_piece;
         ok_in    = item_ok;
         found_in = 1'b0;
      end

      if (cmd.start_scan) begin
         col_in     = '0;
         end_in     = pw;
         run_len_in = '0;
      end

      if (cmd.start_update) begin
         col_in = PW_BITS'(best_x_ff);
         end_in = PW_BITS'(best_x_ff) + w_ff;
         if (total_ff < PT_BITS'(MAX_PIECES)) begin
            total_in = total_ff + PT_BITS'(1);
         end
      end

      if (cmd.start_sweep) begin
         col_in  = '0;
         end_in  = PW_BITS'(MAX_WIDTH);
         area_in = '0;
         cols_in = '0;
      end

      // A position qualifies once the run of equal columns ending here covers
      // the piece width; only a strictly lower top displaces an earlier one.
      if (rd_valid_ff && (cmd.phase == PH_SCAN)) begin
         run_len_in = run_len_next;
         run_h_in   = v;
         if ((run_len_next >= w_ff) && (top <= ph_ext) && (!found_ff || (top < best_top_ff)))
         begin
            found_in    = 1'b1;
            best_top_in = top;
            best_x_in   = start_col[COL_BITS-1:0];
            best_v_in   = v;
         end
      end

      if (rd_valid_ff && (cmd.phase == PH_SWEEP) && (PW_BITS'(rd_col_ff) < pw)
          && (ph_ext > CALC_BITS'(v))) begin
         area_in = area_ff + 24'(ph_ext - CALC_BITS'(v));
         cols_in = cols_ff + 9'd1;
      end

      if (cmd.out_load) begin
         placed_in     = found_ff;
         pos_x_in      = found_ff ? 8'(best_x_ff) : 8'd0;
         pos_y_in      = found_ff ? 16'(best_v_ff) : 16'd0;
         final_in      = last_ff;
         count_in      = last_ff ? 11'(total_ff) : 11'd0;
         waste_area_in = last_ff ? area_ff : 24'd0;
         waste_cols_in = last_ff ? cols_ff : 9'd0;
         if (last_ff) begin
            total_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         end_ff      <= PW_BITS'(MAX_WIDTH);
         rd_valid_ff <= 1'b0;
         total_ff    <= '0;
         ok_ff       <= 1'b0;
         found_ff    <= 1'b0;
         last_ff     <= 1'b0;
      end else begin
         col_ff      <= col_in;
         end_ff      <= end_in;
         rd_valid_ff <= rd_valid_in;
         total_ff    <= total_in;
         ok_ff       <= ok_in;
         found_ff    <= found_in;
         last_ff     <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_col_ff     <= rd_col_in;
      w_ff          <= w_in;
      h_ff          <= h_in;
      run_h_ff      <= run_h_in;
      run_len_ff    <= run_len_in;
      best_x_ff     <= best_x_in;
      best_v_ff     <= best_v_in;
      best_top_ff   <= best_top_in;
      area_ff       <= area_in;
      cols_ff       <= cols_in;
      placed_ff     <= placed_in;
      pos_x_ff      <= pos_x_in;
      pos_y_ff      <= pos_y_in;
      final_ff      <= final_in;
      count_ff      <= count_in;
      waste_area_ff <= waste_area_in;
      waste_cols_ff <= waste_cols_in;
   end

   assign status.busy  = issue || rd_valid_ff;
   assign status.ok    = ok_ff;
   assign status.found = found_ff;
   assign status.last  = last_ff;

   assign rsp_placed        = placed_ff;
   assign rsp_pos_x         = pos_x_ff;
   assign rsp_pos_y         = pos_y_ff;
   assign rsp_final_result  = final_ff;
   assign rsp_placed_count  = count_ff;
   assign rsp_waste_area    = waste_area_ff;
   assign rsp_waste_columns = waste_cols_ff;

`ifndef SYNTHESIS
   a_found_needs_ok: assert property (@(posedge clock) disable iff (reset)
      found_ff |-> ok_ff)
      else $error("position found for a piece that was rejected");

   a_update_in_plate: assert property (@(posedge clock) disable iff (reset)
      (cmd.phase == PH_UPDATE) |-> (end_ff <= pw))
      else $error("skyline update runs past the plate width");
`endif

endmodule

`default_nettype wire
